FILE: rtl/bcc_pkg.sv
package bcc_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TRIM_ANGLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI       = 3'd5;

  localparam logic signed [16:0] TRIM_ANGLE_RST     = 17'sd256;
  localparam logic signed [16:0] SPEED_SETPOINT_RST = 17'sd0;
  localparam logic signed [31:0] UPRIGHT_KP_RST     = 32'sd27525120;
  localparam logic signed [31:0] UPRIGHT_KD_RST     = 32'sd85197;
  localparam logic signed [31:0] SPEED_KP_RST       = -32'sd31457;
  localparam logic signed [31:0] SPEED_KI_RST       = -32'sd157;

  // Shared multiplier and accumulator widths.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = MUL_P_W;

  // Reciprocals for division by 10 and by 5, scaled by 2^24 and rounded down.
  localparam logic signed [MUL_A_W-1:0] RECIP10 = 32'sd1677721;
  localparam logic signed [MUL_A_W-1:0] RECIP5  = 32'sd3355443;

  localparam int INTEGRAL_LIMIT = 7200;

  typedef struct packed {
    logic signed [16:0] trim_angle;
    logic signed [16:0] speed_setpoint;
    logic signed [31:0] upright_kp;
    logic signed [31:0] upright_kd;
    logic signed [31:0] speed_kp;
    logic signed [31:0] speed_ki;
  } bcc_cfg_t;

endpackage

FILE: rtl/bcc_cfg.sv
module bcc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bcc_pkg::bcc_cfg_t                regs
);
  import bcc_pkg::*;

  // Every write is taken as it comes, so the port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trim_angle     <= TRIM_ANGLE_RST;
      regs.speed_setpoint <= SPEED_SETPOINT_RST;
      regs.upright_kp     <= UPRIGHT_KP_RST;
      regs.upright_kd     <= UPRIGHT_KD_RST;
      regs.speed_kp       <= SPEED_KP_RST;
      regs.speed_ki       <= SPEED_KI_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRIM_ANGLE:     regs.trim_angle     <= signed'(cfg_data[16:0]);
        REG_SPEED_SETPOINT: regs.speed_setpoint <= signed'(cfg_data[16:0]);
        REG_UPRIGHT_KP:     regs.upright_kp     <= signed'(cfg_data[31:0]);
        REG_UPRIGHT_KD:     regs.upright_kd     <= signed'(cfg_data[31:0]);
        REG_SPEED_KP:       regs.speed_kp       <= signed'(cfg_data[31:0]);
        REG_SPEED_KI:       regs.speed_ki       <= signed'(cfg_data[31:0]);
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

endmodule

FILE: rtl/bcc_mul.sv
module bcc_mul (
  input  logic                                clk,
  input  logic signed [bcc_pkg::MUL_A_W-1:0]  a,
  input  logic signed [bcc_pkg::MUL_B_W-1:0]  b,
  output logic signed [bcc_pkg::MUL_P_W-1:0]  p
);
  import bcc_pkg::*;

  // One signed product per cycle, registered at the output.
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

FILE: rtl/balance_cascade_controller.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   left_count, right_count, pitch_angle,
//                                            pitch_rate, yaw_rate
// result    out        out_valid / out_stall motor_left, motor_right, speed_out, turn_cmd
// config    in         cfg_valid / cfg_ready cfg_index (register 0..5), cfg_data
//
// A result is loaded once the last step is reached and the result register is free;
// the block returns to idle as it loads the result, and takes no new item before it
// is through with the last one. The single shared 32x26 multiplier sets the pace:
// six products run through it in turn, with correction and saturation steps between.
// Reset (rst, synchronous) restores the register defaults, clears the
// filtered error and the integral, and drops any waiting result.
// A stalled result holds in the output register; the block still takes and
// works the next item, and waits in its last step until the register frees.
module balance_cascade_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [15:0]                left_count,
  input  logic signed [15:0]                right_count,
  input  logic signed [16:0]                pitch_angle,
  input  logic signed [15:0]                pitch_rate,
  input  logic signed [15:0]                yaw_rate,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                motor_left,
  output logic signed [15:0]                motor_right,
  output logic signed [15:0]                speed_out,
  output logic signed [15:0]                turn_cmd,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bcc_pkg::*;

  // Sequencer steps, one per cycle except while waiting in the idle or final step.
  localparam logic [3:0] ST_IDLE   = 4'd0;   // waiting for an item
  localparam logic [3:0] ST_FILT   = 4'd1;   // form 3*err + 7*previous, |3*yaw|
  localparam logic [3:0] ST_DIVMUL = 4'd2;   // multiply |numerator| by 1/10
  localparam logic [3:0] ST_DIVFIX = 4'd3;   // correct quotient, update state, |3*yaw| * 1/5
  localparam logic [3:0] ST_VKP    = 4'd4;   // speed_kp * filtered, finish turn
  localparam logic [3:0] ST_VKI    = 4'd5;   // speed_ki * integral
  localparam logic [3:0] ST_VACC   = 4'd6;   // add the two velocity terms
  localparam logic [3:0] ST_VOUT   = 4'd7;   // truncate and saturate velocity
  localparam logic [3:0] ST_DIFF   = 4'd8;   // pitch error for the upright loop
  localparam logic [3:0] ST_UKP    = 4'd9;   // upright_kp * pitch error
  localparam logic [3:0] ST_UKD    = 4'd10;  // upright_kd * pitch rate
  localparam logic [3:0] ST_UACC   = 4'd11;  // add the rate term scaled by 256
  localparam logic [3:0] ST_UOUT   = 4'd12;  // truncate and saturate upright
  localparam logic [3:0] ST_DONE   = 4'd13;  // hand over to the result register

  localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
  localparam logic signed [ACC_W-1:0] BIAS16   = ACC_W'(65535);
  localparam logic signed [ACC_W-1:0] BIAS24   = ACC_W'(16777215);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32767);
  localparam logic signed [18:0]      INT_HI   = 19'(INTEGRAL_LIMIT);
  localparam logic signed [18:0]      INT_LO   = -19'(INTEGRAL_LIMIT);
  localparam logic signed [13:0]      INT_HI14 = 14'(INTEGRAL_LIMIT);
  localparam logic signed [13:0]      INT_LO14 = -14'(INTEGRAL_LIMIT);

  bcc_cfg_t cfg;

  logic [3:0] state;

  // Captured item.
  logic signed [15:0] l_cnt;
  logic signed [15:0] r_cnt;
  logic signed [16:0] pitch;
  logic signed [15:0] prate;
  logic signed [15:0] yrate;

  // Loop state carried from tick to tick.
  logic signed [17:0] filt;
  logic signed [13:0] integ;

  // Working registers.
  logic [20:0]              abs_n;
  logic                     n_neg;
  logic [16:0]              abs_y3;
  logic                     y_neg;
  logic signed [ACC_W-1:0]  acc;
  logic signed [15:0]       v;
  logic signed [15:0]       u;
  logic signed [15:0]       turn;
  logic signed [MUL_B_W-1:0] diff;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  // Combinational results of the individual steps.
  logic signed [17:0]        err;
  logic signed [21:0]        num;
  logic signed [17:0]        y3;
  logic [17:0]               q10;
  logic [20:0]               r10;
  logic [17:0]               q10_fix;
  logic signed [17:0]        filt_next;
  logic signed [18:0]        isum;
  logic signed [13:0]        integ_next;
  logic [14:0]               q5;
  logic [16:0]               r5;
  logic [14:0]               q5_fix;
  logic signed [15:0]        turn_next;
  logic signed [ACC_W-1:0]   t16;
  logic signed [ACC_W-1:0]   t24;
  logic signed [15:0]        v_next;
  logic signed [15:0]        u_next;
  logic signed [MUL_B_W-1:0] diff_next;
  logic                      in_accept;
  logic                      load_out;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  bcc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // The block takes a new item only between items; the result register is
  // separate, so a waiting result does not hold off the next item.
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_out  = (state == ST_DONE) && (!out_valid || !out_stall);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      ST_DIVMUL: begin
        mul_a = RECIP10;
        mul_b = signed'(MUL_B_W'(abs_n));
      end
      ST_DIVFIX: begin
        mul_a = RECIP5;
        mul_b = signed'(MUL_B_W'(abs_y3));
      end
      ST_VKP: begin
        mul_a = cfg.speed_kp;
        mul_b = MUL_B_W'(filt);
      end
      ST_VKI: begin
        mul_a = cfg.speed_ki;
        mul_b = MUL_B_W'(integ);
      end
      ST_UKP: begin
        mul_a = cfg.upright_kp;
        mul_b = diff;
      end
      ST_UKD: begin
        mul_a = cfg.upright_kd;
        mul_b = MUL_B_W'(prate);
      end
      default: begin
        mul_a = RECIP10;
        mul_b = '0;
      end
    endcase
  end

  // Velocity error and the low-pass numerator; the factors 3 and 7 are
  // shift-and-add.
  always_comb begin
    err = 18'(l_cnt) + 18'(r_cnt) - 18'(cfg.speed_setpoint);
    num = (22'(err) <<< 1) + 22'(err) + (22'(filt) <<< 3) - 22'(filt);
    y3  = (18'(yrate) <<< 1) + 18'(yrate);
  end

  // Division by 10: the reciprocal estimate is at most one low, so a single
  // compare against the remainder fixes it. The sign is put back afterwards,
  // which gives truncation toward zero.
  always_comb begin
    q10       = prod[41:24];
    r10       = abs_n - (21'({q10, 3'b000}) + 21'({q10, 1'b0}));
    q10_fix   = q10 + 18'(r10 >= 21'd10);
    filt_next = n_neg ? -signed'(q10_fix) : signed'(q10_fix);
    isum      = 19'(integ) + 19'(filt_next);
    if (isum > INT_HI) begin
      integ_next = INT_HI14;
    end else if (isum < INT_LO) begin
      integ_next = INT_LO14;
    end else begin
      integ_next = 14'(isum);
    end
  end

  // Turn term: |3*yaw| / 5 in the same way, with the sign flipped.
  always_comb begin
    q5        = prod[38:24];
    r5        = abs_y3 - (17'({q5, 2'b00}) + 17'(q5));
    q5_fix    = q5 + 15'(r5 >= 17'd5);
    turn_next = y_neg ? signed'(16'(q5_fix)) : -signed'(16'(q5_fix));
  end

  // Truncation toward zero of the accumulator, then saturation to 16 bits; also the pitch error.
  always_comb begin
    t16 = (acc + (acc[ACC_W-1] ? BIAS16 : ACC_ZERO)) >>> 16;
    t24 = (acc + (acc[ACC_W-1] ? BIAS24 : ACC_ZERO)) >>> 24;
    if (t16 > SAT_HI) begin
      v_next = 16'(SAT_HI);
    end else if (t16 < SAT_LO) begin
      v_next = 16'(SAT_LO);
    end else begin
      v_next = 16'(t16);
    end
    if (t24 > SAT_HI) begin
      u_next = 16'(SAT_HI);
    end else if (t24 < SAT_LO) begin
      u_next = 16'(SAT_LO);
    end else begin
      u_next = 16'(t24);
    end
    diff_next = MUL_B_W'(pitch)
              - ((MUL_B_W'(v) <<< 8) + MUL_B_W'(cfg.trim_angle));
  end

  // Sequencer and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      filt  <= '0;
      integ <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_FILT;
          end
        end
        ST_FILT:   state <= ST_DIVMUL;
        ST_DIVMUL: state <= ST_DIVFIX;
        ST_DIVFIX: begin
          filt  <= filt_next;
          integ <= integ_next;
          state <= ST_VKP;
        end
        ST_VKP:    state <= ST_VKI;
        ST_VKI:    state <= ST_VACC;
        ST_VACC:   state <= ST_VOUT;
        ST_VOUT:   state <= ST_DIFF;
        ST_DIFF:   state <= ST_UKP;
        ST_UKP:    state <= ST_UKD;
        ST_UKD:    state <= ST_UACC;
        ST_UACC:   state <= ST_UOUT;
        ST_UOUT:   state <= ST_DONE;
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      l_cnt <= left_count;
      r_cnt <= right_count;
      pitch <= pitch_angle;
      prate <= pitch_rate;
      yrate <= yaw_rate;
    end
    if (state == ST_FILT) begin
      n_neg  <= num[21];
      abs_n  <= num[21] ? 21'(-num) : 21'(num);
      y_neg  <= y3[17];
      abs_y3 <= y3[17] ? 17'(-y3) : 17'(y3);
    end
    if (state == ST_VKP) begin
      turn <= turn_next;
    end
    if (state == ST_VKI || state == ST_UKD) begin
      acc <= prod;
    end
    if (state == ST_VACC) begin
      acc <= acc + prod;
    end
    if (state == ST_UACC) begin
      acc <= acc + (prod <<< 8);
    end
    if (state == ST_VOUT) begin
      v <= v_next;
    end
    if (state == ST_DIFF) begin
      diff <= diff_next;
    end
    if (state == ST_UOUT) begin
      u <= u_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      motor_left  <= u;
      motor_right <= -u;
      speed_out   <= v;
      turn_cmd    <= turn;
    end
  end

  // A result only appears out of the final step.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside the final step");

  // An accepted item always starts the sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_FILT)
    else $error("accepted item did not start the sequence");

  // The integral never leaves its clamp.
  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    integ <= INT_HI14 && integ >= INT_LO14)
    else $error("integral outside its limit");

  // The two motor drives are always opposite.
  a_motor_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_right == -motor_left)
    else $error("motor drives are not mirrored");

endmodule

FILE: tb/balance_cascade_controller_test.sv
module balance_cascade_controller_test;
  import bcc_pkg::*;

  // Indexes past the last register. Writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  // The chance, in percent, that a side sits out a cycle.
  localparam int IDLE_PCT = 36;

  // The run's time limit, for about 1700 items with random gaps on both sides;
  // it is several times the slowest correct run.
  localparam int RUN_LIMIT = 4_000_000;

  // One control tick as it goes into the block.
  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [16:0] pitch;
    logic signed [15:0] prate;
    logic signed [15:0] yrate;
  } tick_t;

  // The drive commands that one tick produces.
  typedef struct {
    logic signed [15:0] motor_l;
    logic signed [15:0] motor_r;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
  } drive_t;

  logic clk;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] left_count = '0;
  logic signed [15:0] right_count = '0;
  logic signed [16:0] pitch_angle = '0;
  logic signed [15:0] pitch_rate = '0;
  logic signed [15:0] yaw_rate = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] motor_left;
  logic signed [15:0] motor_right;
  logic signed [15:0] speed_out;
  logic signed [15:0] turn_cmd;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Ticks that still have to be offered, and drive commands that the block
  // still owes, oldest first.
  tick_t ticks_to_send[$];
  drive_t drives_due[$];

  // Our own copy of the block's registers and loop state.
  bcc_cfg_t ctl_regs;
  longint filt_err_q = 0;
  longint err_sum_q = 0;

  tick_t next_tick;
  drive_t want;
  logic in_fire = 1'b0;
  bit calm = 1'b0;
  int errors = 0;

  balance_cascade_controller u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .left_count(left_count),
    .right_count(right_count),
    .pitch_angle(pitch_angle),
    .pitch_rate(pitch_rate),
    .yaw_rate(yaw_rate),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .motor_left(motor_left),
    .motor_right(motor_right),
    .speed_out(speed_out),
    .turn_cmd(turn_cmd),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("FAILURE");
    $finish;
  end

  function automatic longint clip(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Runs one control tick through the cascade and advances the velocity loop
  // state. All products are formed exactly in 64 bits, and each division
  // truncates toward zero, as the hardware does.
  function automatic drive_t predict_drive(input tick_t t);
    longint err, filt, vel, diff, up, turn;
    drive_t d;
    err = longint'(t.left) + longint'(t.right)
        - longint'($signed(ctl_regs.speed_setpoint));
    filt = (3 * err + 7 * filt_err_q) / 10;
    filt_err_q = filt;
    err_sum_q = clip(err_sum_q + filt, INTEGRAL_LIMIT);
    vel = (longint'($signed(ctl_regs.speed_kp)) * filt +
           longint'($signed(ctl_regs.speed_ki)) * err_sum_q) / 65536;
    // The saturated speed term is also the one that tilts the upright set point.
    vel = clip(vel, 32767);
    diff = longint'(t.pitch) - (vel * 256 + longint'($signed(ctl_regs.trim_angle)));
    up = (longint'($signed(ctl_regs.upright_kp)) * diff +
          longint'($signed(ctl_regs.upright_kd)) * longint'(t.prate) * 256) / 16777216;
    up = clip(up, 32767);
    turn = (-3 * longint'(t.yrate)) / 5;
    d.motor_l = 16'(up);
    d.motor_r = 16'(-up);
    d.speed = 16'(vel);
    d.turn = 16'(turn);
    return d;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, exp_val);
    errors++;
  endtask

  // The driver. A new item goes up only once the last one was taken, and it
  // holds still while the block stalls it. Valid never looks at the stall.
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (ticks_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_tick = ticks_to_send.pop_front();
        left_count <= next_tick.left;
        right_count <= next_tick.right;
        pitch_angle <= next_tick.pitch;
        pitch_rate <= next_tick.prate;
        yaw_rate <= next_tick.yrate;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // The monitor. At each rising edge it checks a result that leaves and
  // predicts the result of an item that enters. The two cannot belong to the
  // same item, since a result is registered only after the whole sequence has run.
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (drives_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", motor_left, 0);
      end else begin
        want = drives_due.pop_front();
        if (motor_left !== want.motor_l) report_mismatch("motor_left", motor_left, want.motor_l);
        if (motor_right !== want.motor_r)
          report_mismatch("motor_right", motor_right, want.motor_r);
        if (speed_out !== want.speed) report_mismatch("speed_out", speed_out, want.speed);
        if (turn_cmd !== want.turn) report_mismatch("turn_cmd", turn_cmd, want.turn);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      drives_due.push_back(predict_drive('{left_count, right_count, pitch_angle,
                                           pitch_rate, yaw_rate}));
    end
  end

  task automatic push_tick(input logic [15:0] l, input logic [15:0] r, input logic [16:0] p,
                           input logic [15:0] pr, input logic [15:0] yr);
    tick_t t;
    t.left = l;
    t.right = r;
    t.pitch = p;
    t.prate = pr;
    t.yrate = yr;
    ticks_to_send.push_back(t);
  endtask

  // Uniform values half of the time, with small magnitudes and the corners mixed in.
  function automatic logic [15:0] pick16();
    int r;
    r = $urandom_range(9);
    if (r < 5) return 16'($urandom);
    if (r < 8) return 16'($urandom_range(600) - 300);
    case ($urandom_range(3))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  // Pitch stays mostly within +-180 degrees, but every 17-bit code can occur.
  function automatic logic [16:0] pick_pitch();
    int r;
    r = $urandom_range(9);
    if (r < 5) return 17'($urandom_range(92160) - 46080);
    if (r < 7) return 17'($urandom);
    if (r < 9) return 17'($urandom_range(4000) - 2000);
    return ($urandom_range(1) != 0) ? 17'sd46080 : -17'sd46080;
  endfunction

  // Random ticks in runs. Most runs mimic a robot near balance: the summed
  // wheel counts hover around the setpoint and the pitch near the balance
  // angle, so the integral moves without pinning at its clamp. The other runs
  // are plain noise over every field.
  task automatic queue_random(input int n);
    int remaining, run_len;
    bit noisy;
    logic [15:0] base;
    remaining = n;
    while (remaining > 0) begin
      noisy = ($urandom_range(3) == 0);
      run_len = $urandom_range(20, 1);
      if (run_len > remaining) run_len = remaining;
      repeat (run_len) begin
        if (noisy) begin
          push_tick(pick16(), pick16(), pick_pitch(), pick16(), pick16());
        end else begin
          base = 16'(ctl_regs.speed_setpoint >>> 1);
          push_tick(base + 16'($urandom_range(40)) - 16'd20,
                    base + 16'($urandom_range(40)) - 16'd20,
                    17'(ctl_regs.trim_angle) + 17'($urandom_range(4000)) - 17'd2000,
                    16'($urandom_range(600)) - 16'd300, pick16());
        end
      end
      remaining -= run_len;
    end
  endtask

  // Waits until every item has gone in and every result has come out, then
  // lets the block run on so that anything left over would show up before we
  // move on. The queues and the valid are looked at on rising edges, where
  // the driver leaves them alone.
  task automatic drain();
    do @(posedge clk);
    while (ticks_to_send.size() != 0 || in_valid || drives_due.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  // One register write. It leaves cfg_valid high so that the next write can
  // follow at once; the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TRIM_ANGLE: ctl_regs.trim_angle = data[16:0];
      REG_SPEED_SETPOINT: ctl_regs.speed_setpoint = data[16:0];
      REG_UPRIGHT_KP: ctl_regs.upright_kp = data;
      REG_UPRIGHT_KD: ctl_regs.upright_kd = data;
      REG_SPEED_KP: ctl_regs.speed_kp = data;
      REG_SPEED_KI: ctl_regs.speed_ki = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Rewrites every register, with a write to an unused index slipped in first.
  // Upper bits beyond a register's width are filled with noise on purpose.
  task automatic program_regs(input logic [31:0] trim, input logic [31:0] setp,
                              input logic [31:0] ukp, input logic [31:0] ukd,
                              input logic [31:0] skp, input logic [31:0] ski);
    write_reg(($urandom_range(1) != 0) ? REG_NONE_HI : REG_NONE_LO, $urandom);
    write_reg(REG_TRIM_ANGLE, {15'($urandom), trim[16:0]});
    write_reg(REG_SPEED_SETPOINT, {15'($urandom), setp[16:0]});
    write_reg(REG_UPRIGHT_KP, ukp);
    write_reg(REG_UPRIGHT_KD, ukd);
    write_reg(REG_SPEED_KP, skp);
    write_reg(REG_SPEED_KI, ski);
    cfg_valid <= 1'b0;
  endtask

  // A gain of random sign and magnitude, from tiny to full scale.
  function automatic logic [31:0] pick_gain();
    return $signed($urandom) >>> $urandom_range(31);
  endfunction

  initial begin
    ctl_regs.trim_angle = TRIM_ANGLE_RST;
    ctl_regs.speed_setpoint = SPEED_SETPOINT_RST;
    ctl_regs.upright_kp = UPRIGHT_KP_RST;
    ctl_regs.upright_kd = UPRIGHT_KD_RST;
    ctl_regs.speed_kp = SPEED_KP_RST;
    ctl_regs.speed_ki = SPEED_KI_RST;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Directed ticks under the reset gains. First a quiet robot, then the
    // field corners, and the extreme pitch codes past the nominal range.
    push_tick(16'h0000, 16'h0000, 17'h00000, 16'h0000, 16'h0000);
    push_tick(16'h7fff, 16'h7fff, 17'sd46080, 16'h7fff, 16'h7fff);
    push_tick(16'h8000, 16'h8000, -17'sd46080, 16'h8000, 16'h8000);
    push_tick(16'h7fff, 16'h8000, 17'h0ffff, 16'hffff, 16'h0001);
    push_tick(16'h8000, 16'h7fff, 17'h10000, 16'h0001, 16'hffff);
    // Yaw rates where the turn term truncates toward zero on either side, and two that divide exactly.
    push_tick(16'h0000, 16'h0000, 17'h00100, 16'h0000, 16'h0002);
    push_tick(16'h0000, 16'h0000, 17'h00100, 16'h0000, 16'hfffe);
    push_tick(16'h0000, 16'h0000, 17'h00100, 16'h0000, 16'h0005);
    push_tick(16'h0000, 16'h0000, 17'h00100, 16'h0000, 16'hfffb);
    // A sustained forward error drives the integral to its upper clamp and
    // the upright term into saturation, then a reverse run swings both over.
    repeat (5) push_tick(16'h7fff, 16'h7fff, 17'h00000, 16'h0000, 16'h0000);
    repeat (5) push_tick(16'h8000, 16'h8000, 17'h00000, 16'h0000, 16'h0000);
    // Small errors, with the pitch near the balance angle.
    push_tick(16'h0003, 16'hfffe, 17'h00180, 16'h0040, 16'h0000);
    push_tick(16'hfffd, 16'h0001, 17'h1ff00, 16'hffc0, 16'h0000);
    push_tick(16'h0001, 16'h0000, 17'h00100, 16'h0000, 16'h0000);
    drain();

    // Reset values written back explicitly.
    program_regs(32'(TRIM_ANGLE_RST), 32'(SPEED_SETPOINT_RST), UPRIGHT_KP_RST,
                 UPRIGHT_KD_RST, SPEED_KP_RST, SPEED_KI_RST);
    queue_random(185);
    drain();

    // The gains and the setpoint at their most positive codes, the angle at +180 degrees.
    program_regs(32'sd46080, 32'sd65535, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff);
    queue_random(185);
    drain();

    // The gains and the setpoint at their most negative codes, the angle at -180 degrees.
    program_regs(-32'sd46080, -32'sd65536, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000);
    queue_random(185);
    drain();

    // All registers zero: only the turn term survives.
    program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_random(185);
    drain();

    // Small angle and setpoint, gains of random sign and magnitude.
    program_regs(32'($urandom_range(4000) - 2000), 32'($urandom_range(400) - 200),
                 pick_gain(), pick_gain(), pick_gain(), pick_gain());
    queue_random(185);
    drain();

    // Register codes past the nominal ranges of the angle and the setpoint.
    program_regs(32'h0000ffff, 32'h00010000, pick_gain(), pick_gain(),
                 pick_gain(), pick_gain());
    queue_random(185);
    drain();

    // Fully random register contents.
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(185);
    drain();

    // A stretch with neither side idling, back on the reset gains.
    calm = 1'b1;
    program_regs(32'(TRIM_ANGLE_RST), 32'(SPEED_SETPOINT_RST), UPRIGHT_KP_RST,
                 UPRIGHT_KD_RST, SPEED_KP_RST, SPEED_KI_RST);
    queue_random(185);
    drain();
    calm = 1'b0;

    program_regs(32'($urandom_range(92160) - 46080), 32'($urandom), pick_gain(),
                 pick_gain(), pick_gain(), pick_gain());
    queue_random(185);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
